// ===== sv/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants of the detector pairing table
// Entry layout, operation and status codes, controller states and the
// command word from the controller to the ring of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

  // table size and derived widths
  localparam int NUM_ENTRIES = 32;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

  // one stored detector
  typedef struct packed {
    logic       valid;
    logic [5:0] id;
    logic [7:0] code_low;
    logic [7:0] code_mid;
    logic [7:0] code_high;
    logic [3:0] sensor_kind;
    logic [3:0] zone_kind;
  } entry_t;

  // operation codes
  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_MATCH  = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_READ   = 3'd3,
    MODE_WRITE  = 3'd4
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_MISS  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // controller to ring: rotate all cells, or load one cell
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } ring_cmd_t;

endpackage

`default_nettype wire

// ===== sv/detector_pairing_table_top.sv =====
// ----------------------------------------------------------------------------
// detector_pairing_table_top: table of paired wireless detectors
// Entries sit in a ring of cells that turns once per command under a
// controller that watches the head cell.
// ----------------------------------------------------------------------------
// Every command runs from the start edge to the edge that takes its result
// through one full turn of the cell ring past the head cell, a step that
// forms the result and loads the changed entry, and the cycle in which the
// result strobe shows. busy is high through the turn and that step, and
// start is taken again in the cycle the result strobe shows, so a new command
// can follow as soon as the result of the last one shows. The result is on
// the out_ ports for exactly one cycle with out_strobe high and cannot be held
// off, so the receiver must take it then. The table is empty after reset.
`default_nettype none

module detector_pairing_table_top
  import dpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_code_low,
  input  wire logic [7:0] in_code_mid,
  input  wire logic [7:0] in_code_high,
  input  wire logic [3:0] in_sensor_kind,
  input  wire logic [3:0] in_zone_kind,
  input  wire logic [5:0] in_detector_id,
  input  wire logic [7:0] in_slot,
  input  wire logic       in_valid_in,
  output logic            out_strobe,
  output logic [1:0]      out_status,
  output logic [4:0]      out_slot_out,
  output logic [5:0]      out_id_out,
  output logic            out_valid_out,
  output logic [7:0]      out_code_low_out,
  output logic [7:0]      out_code_mid_out,
  output logic [7:0]      out_code_high_out,
  output logic [3:0]      out_sensor_kind_out,
  output logic [3:0]      out_zone_kind_out,
  output logic [5:0]      out_valid_count
);

  entry_t    cell_q [NUM_ENTRIES];
  ring_cmd_t cmd;

  // controller
  dpt_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_code_low         (in_code_low),
    .in_code_mid         (in_code_mid),
    .in_code_high        (in_code_high),
    .in_sensor_kind      (in_sensor_kind),
    .in_zone_kind        (in_zone_kind),
    .in_detector_id      (in_detector_id),
    .in_slot             (in_slot),
    .in_valid_in         (in_valid_in),
    .head_i              (cell_q[0]),
    .cmd_o               (cmd),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_slot_out        (out_slot_out),
    .out_id_out          (out_id_out),
    .out_valid_out       (out_valid_out),
    .out_code_low_out    (out_code_low_out),
    .out_code_mid_out    (out_code_mid_out),
    .out_code_high_out   (out_code_high_out),
    .out_sensor_kind_out (out_sensor_kind_out),
    .out_zone_kind_out   (out_zone_kind_out),
    .out_valid_count     (out_valid_count)
  );

  // ring of entry cells, each takes its upper neighbor, the last wraps to head
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    entry_t nbr;
    logic   load_en;

    if (i == NUM_ENTRIES - 1) begin : g_wrap
      assign nbr = cell_q[0];
    end else begin : g_next
      assign nbr = cell_q[i + 1];
    end

    assign load_en = cmd.load && (cmd.idx == IDX_W'(i));

    dpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (cmd.shift),
      .nbr_i    (nbr),
      .load_en  (load_en),
      .load_i   (cmd.data),
      .entry_o  (cell_q[i])
    );
  end

endmodule

`default_nettype wire

// ===== sv/dpt_cell.sv =====
// ----------------------------------------------------------------------------
// dpt_cell: one entry of the pairing table
// Holds one entry; takes its neighbor's entry when the ring rotates, or a
// new entry when the controller loads this cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_cell
  import dpt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   shift_en,
  input  wire entry_t nbr_i,
  input  wire logic   load_en,
  input  wire entry_t load_i,
  output entry_t      entry_o
);

  entry_t entry_r;

  // entry register, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (load_en) begin
      entry_r <= load_i;
    end else if (shift_en) begin
      entry_r <= nbr_i;
    end
  end

  assign entry_o = entry_r;

endmodule

`default_nettype wire

// ===== sv/dpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpt_ctrl: scan controller of the pairing table
// Takes one command word, watches the head cell while the ring makes one
// full turn, then forms the result and loads the changed entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ctrl
  import dpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_code_low,
  input  wire logic [7:0] in_code_mid,
  input  wire logic [7:0] in_code_high,
  input  wire logic [3:0] in_sensor_kind,
  input  wire logic [3:0] in_zone_kind,
  input  wire logic [5:0] in_detector_id,
  input  wire logic [7:0] in_slot,
  input  wire logic       in_valid_in,
  input  wire entry_t     head_i,
  output ring_cmd_t       cmd_o,
  output logic            out_strobe,
  output logic [1:0]      out_status,
  output logic [4:0]      out_slot_out,
  output logic [5:0]      out_id_out,
  output logic            out_valid_out,
  output logic [7:0]      out_code_low_out,
  output logic [7:0]      out_code_mid_out,
  output logic [7:0]      out_code_high_out,
  output logic [3:0]      out_sensor_kind_out,
  output logic [3:0]      out_zone_kind_out,
  output logic [5:0]      out_valid_count
);

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_ENTRIES - 1);

  state_t state_r, state_nxt;

  // captured command word
  logic [2:0]       mode_r;
  entry_t           new_r;
  logic [7:0]       tgt_r;
  logic             inrng_r;

  // scan results
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] fslot_r, fslot_nxt;
  logic [5:0]       fid_r, fid_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_slot_r, free_slot_nxt;
  entry_t           tgt_e_r, tgt_e_nxt;

  // result registers
  logic             strobe_r;
  logic [1:0]       status_r, status_nxt;
  logic [4:0]       slot_o_r, slot_o_nxt;
  logic [5:0]       id_o_r, id_o_nxt;
  entry_t           rd_r, rd_nxt;
  logic [5:0]       vcnt_r, vcnt_nxt;

  logic             accept;
  logic [8:0]       slot_w;
  logic [8:0]       did_w;
  logic             slot_ok;
  logic             did_ok;
  logic             is_match;
  logic [7:0]       step_w;
  logic [7:0]       fslot_w;
  logic [7:0]       free_w;
  logic [7:0]       free_id_w;
  logic [CNT_W-1:0] cnt_fin;
  logic [7:0]       cnt_w;

  assign accept = start && !busy;

  // range checks on the incoming word
  assign slot_w  = {1'b0, in_slot};
  assign did_w   = {3'b000, in_detector_id};
  assign slot_ok = slot_w < 9'(NUM_ENTRIES);
  assign did_ok  = (did_w != 9'd0) && (did_w <= 9'(NUM_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (step_r == LAST_STEP) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake output
  always_comb begin
    case (state_r)
      ST_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  // per-step look at the head cell
  assign is_match = head_i.valid && (head_i.code_mid == new_r.code_mid) &&
                    (head_i.code_high == new_r.code_high);
  assign step_w   = 8'(step_r);

  always_comb begin
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    fslot_nxt     = fslot_r;
    fid_nxt       = fid_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    tgt_e_nxt     = tgt_e_r;
    if (accept) begin
      step_nxt  = '0;
      cnt_nxt   = '0;
      found_nxt = 1'b0;
      free_nxt  = 1'b0;
    end else if (state_r == ST_SCAN) begin
      step_nxt = step_r + 1'b1;
      if (head_i.valid) cnt_nxt = cnt_r + 1'b1;
      if (!found_r && is_match) begin
        found_nxt = 1'b1;
        fslot_nxt = step_r;
        fid_nxt   = head_i.id;
      end
      if (!free_r && !head_i.valid) begin
        free_nxt      = 1'b1;
        free_slot_nxt = step_r;
      end
      if (step_w == tgt_r) tgt_e_nxt = head_i;
    end
  end

  // result and store update once the ring is back in place
  assign fslot_w   = 8'(fslot_r);
  assign free_w    = 8'(free_slot_r);
  assign free_id_w = free_w + 8'd1;
  assign cnt_w     = 8'(cnt_fin);
  assign vcnt_nxt  = cnt_w[5:0];

  always_comb begin
    status_nxt  = STAT_RANGE;
    slot_o_nxt  = '0;
    id_o_nxt    = '0;
    rd_nxt      = '0;
    cnt_fin     = cnt_r;
    cmd_o       = '0;
    cmd_o.shift = (state_r == ST_SCAN);
    cmd_o.idx   = tgt_r[IDX_W-1:0];
    case (mode_r)
      MODE_ADD, MODE_MATCH: begin
        if (found_r) begin
          status_nxt = STAT_OK;
          slot_o_nxt = fslot_w[4:0];
          id_o_nxt   = fid_r;
        end else if (mode_r == MODE_ADD && free_r) begin
          status_nxt     = STAT_OK;
          slot_o_nxt     = free_w[4:0];
          id_o_nxt       = free_id_w[5:0];
          cnt_fin        = cnt_r + 1'b1;
          cmd_o.load     = 1'b1;
          cmd_o.idx      = free_slot_r;
          cmd_o.data     = new_r;
          cmd_o.data.valid = 1'b1;
          cmd_o.data.id  = free_id_w[5:0];
        end else begin
          status_nxt = STAT_MISS;
        end
      end
      MODE_DELETE: begin
        if (inrng_r) begin
          status_nxt = STAT_OK;
          slot_o_nxt = tgt_r[4:0];
          cnt_fin    = cnt_r - CNT_W'(tgt_e_r.valid);
          cmd_o.load = 1'b1;
        end
      end
      MODE_READ: begin
        if (inrng_r) begin
          status_nxt = STAT_OK;
          slot_o_nxt = tgt_r[4:0];
          id_o_nxt   = tgt_e_r.id;
          rd_nxt     = tgt_e_r;
        end
      end
      MODE_WRITE: begin
        if (inrng_r) begin
          status_nxt = STAT_OK;
          slot_o_nxt = tgt_r[4:0];
          cnt_fin    = cnt_r - CNT_W'(tgt_e_r.valid) + CNT_W'(new_r.valid);
          cmd_o.load = 1'b1;
          cmd_o.data = new_r;
        end
      end
      default: status_nxt = STAT_RANGE;
    endcase
    cmd_o.load = cmd_o.load && (state_r == ST_DONE);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      step_r   <= '0;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_DONE);
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
      found_r  <= found_nxt;
      free_r   <= free_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fslot_r     <= fslot_nxt;
    fid_r       <= fid_nxt;
    free_slot_r <= free_slot_nxt;
    tgt_e_r     <= tgt_e_nxt;
    if (accept) begin
      mode_r            <= in_mode;
      new_r.valid       <= in_valid_in;
      new_r.id          <= in_detector_id;
      new_r.code_low    <= in_code_low;
      new_r.code_mid    <= in_code_mid;
      new_r.code_high   <= in_code_high;
      new_r.sensor_kind <= in_sensor_kind;
      new_r.zone_kind   <= in_zone_kind;
      if (in_mode == MODE_DELETE) begin
        tgt_r   <= 8'(in_detector_id) - 8'd1;
        inrng_r <= did_ok;
      end else begin
        tgt_r   <= in_slot;
        inrng_r <= slot_ok;
      end
    end
    if (state_r == ST_DONE) begin
      status_r <= status_nxt;
      slot_o_r <= slot_o_nxt;
      id_o_r   <= id_o_nxt;
      rd_r     <= rd_nxt;
      vcnt_r   <= vcnt_nxt;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_slot_out        = slot_o_r;
  assign out_id_out          = id_o_r;
  assign out_valid_out       = rd_r.valid;
  assign out_code_low_out    = rd_r.code_low;
  assign out_code_mid_out    = rd_r.code_mid;
  assign out_code_high_out   = rd_r.code_high;
  assign out_sensor_kind_out = rd_r.sensor_kind;
  assign out_zone_kind_out   = rd_r.zone_kind;
  assign out_valid_count     = vcnt_r;

endmodule

`default_nettype wire

// ===== sv/dpt_checker.sv =====
// ----------------------------------------------------------------------------
// dpt_checker: port-level checks of the pairing table
// Watches the command and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_checker
  import dpt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [1:0] out_status,
  input wire logic [4:0] out_slot_out,
  input wire logic [5:0] out_id_out
);

  // an accepted word makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // each result word is shown for one cycle only
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  // a command ends exactly with its result word
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result word");

  // a result word never overlaps a running command
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while busy");

  // failed commands report no slot and no id
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != STAT_OK) |-> (out_slot_out == 5'd0 && out_id_out == 6'd0))
    else $error("failed command carries a slot or id");

endmodule

bind detector_pairing_table_top dpt_checker u_dpt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_status   (out_status),
  .out_slot_out (out_slot_out),
  .out_id_out   (out_id_out)
);

`default_nettype wire

// ===== test/detector_pairing_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// detector_pairing_table_top_tb: self-checking bench for the pairing table
// Runs a table of directed commands (empty table, extreme fields, every
// operation, range errors), then phases of random traffic.
// Each accepted command goes through a local model of the table. Every
// result word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------

module detector_pairing_table_top_tb;
  import dpt_pkg::*;

  // codes outside the defined operations
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int         MAX_GAP        = 40;
  localparam int         DRAIN_CYCLES   = 2 * NUM_ENTRIES + 8;

  // one command word
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] clo;
    logic [7:0] cmid;
    logic [7:0] chigh;
    logic [3:0] sk;
    logic [3:0] zk;
    logic [5:0] did;
    logic [7:0] slot;
    logic       vin;
  } command_t;

  // one result word
  typedef struct packed {
    status_t    status;
    logic [4:0] slot;
    logic [5:0] id;
    logic       valid;
    logic [7:0] clo;
    logic [7:0] cmid;
    logic [7:0] chigh;
    logic [3:0] sk;
    logic [3:0] zk;
    logic [5:0] count;
  } result_t;

  // directed row: command plus an optional hand-written result
  typedef struct {
    command_t cmd;
    bit       typed;
    result_t  res;
  } vector_t;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       start          = 1'b0;
  logic [2:0] in_mode        = '0;
  logic [7:0] in_code_low    = '0;
  logic [7:0] in_code_mid    = '0;
  logic [7:0] in_code_high   = '0;
  logic [3:0] in_sensor_kind = '0;
  logic [3:0] in_zone_kind   = '0;
  logic [5:0] in_detector_id = '0;
  logic [7:0] in_slot        = '0;
  logic       in_valid_in    = 1'b0;
  logic       busy;
  logic       out_strobe;
  logic [1:0] out_status;
  logic [4:0] out_slot_out;
  logic [5:0] out_id_out;
  logic       out_valid_out;
  logic [7:0] out_code_low_out;
  logic [7:0] out_code_mid_out;
  logic [7:0] out_code_high_out;
  logic [3:0] out_sensor_kind_out;
  logic [3:0] out_zone_kind_out;
  logic [5:0] out_valid_count;

  entry_t  pair_mem [NUM_ENTRIES];
  result_t awaited_results [$];
  vector_t script [25];
  int      mismatch_count = 0;

  detector_pairing_table_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_code_low         (in_code_low),
    .in_code_mid         (in_code_mid),
    .in_code_high        (in_code_high),
    .in_sensor_kind      (in_sensor_kind),
    .in_zone_kind        (in_zone_kind),
    .in_detector_id      (in_detector_id),
    .in_slot             (in_slot),
    .in_valid_in         (in_valid_in),
    .out_strobe          (out_strobe),
    .out_status          (out_status),
    .out_slot_out        (out_slot_out),
    .out_id_out          (out_id_out),
    .out_valid_out       (out_valid_out),
    .out_code_low_out    (out_code_low_out),
    .out_code_mid_out    (out_code_mid_out),
    .out_code_high_out   (out_code_high_out),
    .out_sensor_kind_out (out_sensor_kind_out),
    .out_zone_kind_out   (out_zone_kind_out),
    .out_valid_count     (out_valid_count)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic command_t mk_cmd(input logic [2:0] mode, input logic [7:0] clo,
                                      input logic [7:0] cmid, input logic [7:0] chigh,
                                      input logic [3:0] sk, input logic [3:0] zk,
                                      input logic [5:0] did, input logic [7:0] slot,
                                      input logic vin);
    command_t c;
    c = '{mode, clo, cmid, chigh, sk, zk, did, slot, vin};
    return c;
  endfunction

  function automatic result_t mk_res(input status_t st, input logic [4:0] slot,
                                     input logic [5:0] id, input logic valid,
                                     input logic [7:0] clo, input logic [7:0] cmid,
                                     input logic [7:0] chigh, input logic [3:0] sk,
                                     input logic [3:0] zk, input logic [5:0] count);
    result_t r;
    r = '{st, slot, id, valid, clo, cmid, chigh, sk, zk, count};
    return r;
  endfunction

  // apply one command to the local table and form its result word
  function automatic result_t pair_table_apply(input command_t c);
    result_t r;
    bit      done;
    int      n;
    r        = '0;
    r.status = STAT_RANGE;
    done     = 1'b0;
    n        = 0;
    case (c.mode)
      MODE_ADD, MODE_MATCH: begin
        r.status = STAT_MISS;
        // first valid entry with the same middle and high code bytes
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (!done && pair_mem[i].valid && pair_mem[i].code_mid == c.cmid &&
              pair_mem[i].code_high == c.chigh) begin
            r.status = STAT_OK;
            r.slot   = 5'(i);
            r.id     = pair_mem[i].id;
            done     = 1'b1;
          end
        end
        // new detector goes into the lowest free slot
        if (c.mode == MODE_ADD) begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (!done && !pair_mem[i].valid) begin
              pair_mem[i].valid       = 1'b1;
              pair_mem[i].id          = 6'(i + 1);
              pair_mem[i].code_low    = c.clo;
              pair_mem[i].code_mid    = c.cmid;
              pair_mem[i].code_high   = c.chigh;
              pair_mem[i].sensor_kind = c.sk;
              pair_mem[i].zone_kind   = c.zk;
              r.status                = STAT_OK;
              r.slot                  = 5'(i);
              r.id                    = 6'(i + 1);
              done                    = 1'b1;
            end
          end
        end
      end
      MODE_DELETE: begin
        if (c.did >= 1 && c.did <= NUM_ENTRIES) begin
          pair_mem[c.did - 1] = '0;
          r.status            = STAT_OK;
          r.slot              = 5'(c.did - 1);
        end
      end
      MODE_READ: begin
        if (c.slot < NUM_ENTRIES) begin
          r.status = STAT_OK;
          r.slot   = c.slot[4:0];
          r.id     = pair_mem[c.slot].id;
          r.valid  = pair_mem[c.slot].valid;
          r.clo    = pair_mem[c.slot].code_low;
          r.cmid   = pair_mem[c.slot].code_mid;
          r.chigh  = pair_mem[c.slot].code_high;
          r.sk     = pair_mem[c.slot].sensor_kind;
          r.zk     = pair_mem[c.slot].zone_kind;
        end
      end
      MODE_WRITE: begin
        if (c.slot < NUM_ENTRIES) begin
          pair_mem[c.slot].valid       = c.vin;
          pair_mem[c.slot].id          = c.did;
          pair_mem[c.slot].code_low    = c.clo;
          pair_mem[c.slot].code_mid    = c.cmid;
          pair_mem[c.slot].code_high   = c.chigh;
          pair_mem[c.slot].sensor_kind = c.sk;
          pair_mem[c.slot].zone_kind   = c.zk;
          r.status                     = STAT_OK;
          r.slot                       = c.slot[4:0];
        end
      end
      default: ;
    endcase
    if (r.status != STAT_OK) begin
      r.slot = '0;
      r.id   = '0;
    end
    for (int i = 0; i < NUM_ENTRIES; i++) n += pair_mem[i].valid;
    r.count = 6'(n);
    return r;
  endfunction

  // drive one command word and hold it until the block takes it
  task automatic send_word(input command_t c);
    in_mode        <= c.mode;
    in_code_low    <= c.clo;
    in_code_mid    <= c.cmid;
    in_code_high   <= c.chigh;
    in_sensor_kind <= c.sk;
    in_zone_kind   <= c.zk;
    in_detector_id <= c.did;
    in_slot        <= c.slot;
    in_valid_in    <= c.vin;
    start          <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // random pause on the command side, counted from when the block is free
  task automatic idle_gap(input bit allow);
    int gap;
    if (allow && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      @(posedge clk);
      while (busy !== 1'b0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", what, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("slot_out", want.slot, out_slot_out);
        check_field("id_out", want.id, out_id_out);
        check_field("valid_out", want.valid, out_valid_out);
        check_field("code_low_out", want.clo, out_code_low_out);
        check_field("code_mid_out", want.cmid, out_code_mid_out);
        check_field("code_high_out", want.chigh, out_code_high_out);
        check_field("sensor_kind_out", want.sk, out_sensor_kind_out);
        check_field("zone_kind_out", want.zk, out_zone_kind_out);
        check_field("valid_count", want.count, out_valid_count);
      end
    end
  end

  // stimulus
  initial begin
    command_t c;
    result_t  predicted;
    int       burst;
    int       pick;
    foreach (pair_mem[i]) pair_mem[i] = '0;

    // empty table, reads at and beyond the edges
    script[0]  = '{mk_cmd(MODE_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0)};
    script[1]  = '{mk_cmd(MODE_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd31, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd31, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0)};
    script[2]  = '{mk_cmd(MODE_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd32, 1'b0),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0)};
    script[3]  = '{mk_cmd(MODE_READ, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 6'd63, 8'd255, 1'b1),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0)};
    script[4]  = '{mk_cmd(MODE_MATCH, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_MISS, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0)};
    // adds: two new entries, then one that finds an existing entry
    script[5]  = '{mk_cmd(MODE_ADD, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd0, 6'd1, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd1)};
    script[6]  = '{mk_cmd(MODE_ADD, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd1, 6'd2, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    script[7]  = '{mk_cmd(MODE_ADD, 8'h12, 8'hFF, 8'hFF, 4'h3, 4'h4, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd0, 6'd1, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    script[8]  = '{mk_cmd(MODE_MATCH, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd0, 6'd1, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    script[9]  = '{mk_cmd(MODE_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd0, 6'd1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF, 6'd2)};
    // write the last slot with a wide id, read it back
    script[10] = '{mk_cmd(MODE_WRITE, 8'hA5, 8'h5A, 8'hC3, 4'h9, 4'h6, 6'd63, 8'd31, 1'b1),
                   1'b1, mk_res(STAT_OK, 5'd31, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd3)};
    script[11] = '{mk_cmd(MODE_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd31, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd31, 6'd63, 1'b1, 8'hA5, 8'h5A, 8'hC3, 4'h9, 4'h6, 6'd3)};
    // delete: id zero and ids beyond the table, then the last slot
    script[12] = '{mk_cmd(MODE_DELETE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd3)};
    script[13] = '{mk_cmd(MODE_DELETE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd33, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd3)};
    script[14] = '{mk_cmd(MODE_DELETE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd63, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd3)};
    script[15] = '{mk_cmd(MODE_DELETE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd32, 8'd0, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd31, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    script[16] = '{mk_cmd(MODE_READ, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd0, 8'd31, 1'b0),
                   1'b1, mk_res(STAT_OK, 5'd31, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    // write out of range and unknown operations
    script[17] = '{mk_cmd(MODE_WRITE, 8'h77, 8'h77, 8'h77, 4'h7, 4'h7, 6'd7, 8'd32, 1'b1),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    script[18] = '{mk_cmd(MODE_UNUSED_LO, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0, 6'd1, 8'd0, 1'b1),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    script[19] = '{mk_cmd(MODE_UNUSED_HI, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0, 6'd1, 8'd0, 1'b1),
                   1'b1, mk_res(STAT_RANGE, 5'd0, 6'd0, 1'b0, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd2)};
    // invalid entry holding codes, duplicate codes, first-match order
    script[20] = '{mk_cmd(MODE_WRITE, 8'h11, 8'h22, 8'h33, 4'h5, 4'hA, 6'd7, 8'd5, 1'b0),
                   1'b0, '0};
    script[21] = '{mk_cmd(MODE_WRITE, 8'h00, 8'hFF, 8'hFF, 4'h1, 4'h2, 6'd40, 8'd2, 1'b1),
                   1'b0, '0};
    script[22] = '{mk_cmd(MODE_DELETE, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 6'd1, 8'd0, 1'b0),
                   1'b0, '0};
    script[23] = '{mk_cmd(MODE_MATCH, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0, 6'd0, 8'd0, 1'b0),
                   1'b0, '0};
    script[24] = '{mk_cmd(MODE_ADD, 8'h44, 8'h22, 8'h33, 4'hC, 4'h3, 6'd0, 8'd0, 1'b0),
                   1'b0, '0};

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (script[n]) begin
      send_word(script[n].cmd);
      predicted = pair_table_apply(script[n].cmd);
      awaited_results.push_back(script[n].typed ? script[n].res : predicted);
      idle_gap(1'b1);
    end

    // random phases: every third one fills the table past full
    for (int p = 0; p < 9; p++) begin
      burst = (p % 3 == 1) ? 40 : 52;
      for (int k = 0; k < burst; k++) begin
        c.clo  = 8'($urandom);
        c.cmid = 8'($urandom);
        c.chigh = 8'($urandom);
        c.sk   = 4'($urandom);
        c.zk   = 4'($urandom);
        c.did  = 6'($urandom);
        c.slot = 8'($urandom);
        c.vin  = ($urandom_range(0, 99) < 75);
        if (p % 3 == 1) begin
          // distinct high byte per word so each add takes a new slot
          c.mode  = MODE_ADD;
          c.chigh = 8'(k);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 30)      c.mode = MODE_ADD;
          else if (pick < 50) c.mode = MODE_MATCH;
          else if (pick < 65) c.mode = MODE_DELETE;
          else if (pick < 78) c.mode = MODE_READ;
          else if (pick < 93) c.mode = MODE_WRITE;
          else                c.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
          // small code pool so adds and matches hit existing entries
          if ($urandom_range(0, 99) < 70) begin
            c.cmid  = 8'h40 + 8'($urandom_range(0, 5));
            c.chigh = 8'hC0 | 8'($urandom_range(0, 1));
          end
          if ($urandom_range(0, 99) < 85) c.did = 6'($urandom_range(1, NUM_ENTRIES));
          if ($urandom_range(0, 99) < 85) c.slot = 8'($urandom_range(0, NUM_ENTRIES - 1));
        end
        send_word(c);
        awaited_results.push_back(pair_table_apply(c));
        // phases four and five run back to back with no pauses
        idle_gap(p != 4 && p != 5);
      end
    end
    if (start) start <= 1'b0;

    // drain
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
